[rtl/cfe_pkg.sv]
// Package for the COBS frame encoder: sizes, codes, the command that the
// front hands to the back, and the back's state encoding.
// No dependencies.
package cfe_pkg;

   // Result word packing
   localparam int BYTES_PER_WORD = 8;
   localparam int LANE_CNT_W     = $clog2(BYTES_PER_WORD);

   // COBS block limits
   localparam int          BLOCK_DEPTH = 254;
   localparam logic [7:0]  FULL_CODE   = 8'hFF;
   localparam logic [7:0]  EMPTY_CODE  = 8'h01;
   localparam logic [7:0]  DELIM_BYTE  = 8'h00;

   // Block store: two banks of 256 entries, bank bit on top
   localparam int STORE_DEPTH  = 512;
   localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

   // One command per item that produces output.
   // a: full block (code 0xFF) pending from an earlier item
   // m: block closed by a zero byte or by frame end
   // one_valid: extra empty block (zero byte that also ends the frame)
   // eof: frame delimiter follows
   typedef struct packed {
      logic       a_valid;
      logic       a_bank;
      logic       m_valid;
      logic [7:0] m_code;
      logic       m_bank;
      logic       one_valid;
      logic       eof;
   } cmd_type;

   // Back tells the front that a bank has been read out
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_A_CODE,
      BK_A_DATA,
      BK_M_CODE,
      BK_M_DATA,
      BK_ONE,
      BK_DELIM
   } bk_state_type;

endpackage

[rtl/cfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/cfe_front.sv]
// Front end: accepts raw bytes, tracks the open block code and bank, writes
// non-zero bytes to the block store and queues one command per output run.
// Depends on cfe_pkg.
module cfe_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_end_of_frame,
   input  logic                            cmdq_full,
   output logic                            cmdq_push,
   output cfe_pkg::cmd_type                cmdq_data,
   output logic                            st_wr_en,
   output logic [cfe_pkg::STORE_ADDR_W-1:0] st_wr_addr,
   output logic [7:0]                      st_wr_data,
   input  cfe_pkg::release_type            bank_rel
);
   import cfe_pkg::*;

   logic [7:0] code_ff, code_in;
   logic       bank_ff, bank_in;
   logic [1:0] busy_ff, busy_in;

   logic       accept;
   logic       nonzero;
   logic       full_pend;
   logic       tgt_bank;
   logic [7:0] code1, code2;
   logic       m_flush;

   // Classify the offered byte
   always_comb begin
      nonzero   = (req_data_byte != 8'h00);
      full_pend = (code_ff == FULL_CODE);
      tgt_bank  = full_pend ? ~bank_ff : bank_ff;
      code1     = full_pend ? EMPTY_CODE : code_ff;
      code2     = nonzero ? code1 + 8'd1 : code1;
      m_flush   = ~nonzero | req_end_of_frame;
   end

   // Stall when the queue is full or a non-zero byte's write bank is still being read out
   assign req_ready = ~cmdq_full & ~(nonzero & busy_ff[tgt_bank]);
   assign accept    = req_valid & req_ready;

   // Store write of a non-zero byte into the open block
   assign st_wr_en   = accept & nonzero;
   assign st_wr_addr = {tgt_bank, code1 - 8'd1};
   assign st_wr_data = req_data_byte;

   // Command for the back end
   always_comb begin
      cmdq_push           = accept & (full_pend | m_flush);
      cmdq_data.a_valid   = full_pend;
      cmdq_data.a_bank    = bank_ff;
      cmdq_data.m_valid   = m_flush;
      cmdq_data.m_code    = code2;
      cmdq_data.m_bank    = tgt_bank;
      cmdq_data.one_valid = ~nonzero & req_end_of_frame;
      cmdq_data.eof       = req_end_of_frame;
   end

   // Next block state and bank ownership
   always_comb begin
      code_in = code_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (bank_rel.valid) begin
         busy_in[bank_rel.bank] = 1'b0;
      end
      if (accept) begin
         if (full_pend) begin
            busy_in[bank_ff] = 1'b1;
         end
         code_in = code2;
         bank_in = tgt_bank;
         if (m_flush) begin
            code_in = EMPTY_CODE;
            if (code2 != EMPTY_CODE) begin
               busy_in[tgt_bank] = 1'b1;
               bank_in           = ~tgt_bank;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= EMPTY_CODE;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         code_ff <= code_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

[rtl/cfe_cmd_fifo.sv]
// Short command queue between the front and back ends.
// Depends on cfe_pkg.
module cfe_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cfe_pkg::cmd_type push_data,
   input  logic             pop,
   output cfe_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import cfe_pkg::*;

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CMDQ_PTR_W:0]    count_ff;

   assign head  = entry_ff[rd_ptr_ff];
   assign full  = (count_ff == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
   assign empty = (count_ff == '0);

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push & ~pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop & ~push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/cfe_back.sv]
// Back end: walks each command one byte per cycle while the output is not stalled
// (code bytes, stored bytes, delimiter) and packs the byte stream into result words.
// Depends on cfe_pkg.
module cfe_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmdq_empty,
   input  cfe_pkg::cmd_type                 cmdq_head,
   output logic                             cmdq_pop,
   output logic                             st_rd_en,
   output logic [cfe_pkg::STORE_ADDR_W-1:0] st_rd_addr,
   input  logic [7:0]                       st_rd_data,
   output cfe_pkg::release_type             bank_rel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [63:0]                      rsp_out_bytes,
   output logic [3:0]                       rsp_byte_count,
   output logic                             rsp_last_of_run,
   output logic                             rsp_frame_done
);
   import cfe_pkg::*;

   bk_state_type state_ff, state_in;
   cmd_type      cmd_ff, cmd_in;
   logic [7:0]   idx_ff, idx_in;

   // Byte issue
   logic       iss;
   logic       iss_ram;
   logic [7:0] iss_const;
   logic       iss_final;
   logic       issue_ok;
   bk_state_type after_m;

   // Presented byte stage
   logic       pv_ff, p_ram_ff, p_final_ff, p_eof_ff;
   logic [7:0] p_const_ff;
   logic [7:0] p_byte;

   // Packer
   logic                  pk_ready;
   logic                  consume;
   logic [LANE_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]           acc_ff, acc_in;
   logic [63:0]           merged;
   logic                  word_done;

   logic        ov_ff;
   logic [63:0] ob_ff;
   logic [3:0]  oc_ff;
   logic        ol_ff, of_ff;

   assign pk_ready = ~ov_ff | rsp_ready;
   assign consume  = pv_ff & pk_ready;
   assign issue_ok = ~pv_ff | consume;
   assign p_byte   = p_ram_ff ? st_rd_data : p_const_ff;

   assign after_m = cmd_ff.one_valid ? BK_ONE : (cmd_ff.eof ? BK_DELIM : BK_IDLE);

   // Sequencer: next state and byte issue
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      cmdq_pop  = 1'b0;
      iss       = 1'b0;
      iss_ram   = 1'b0;
      iss_const = DELIM_BYTE;
      iss_final = 1'b0;
      st_rd_addr = {cmd_ff.a_bank, idx_ff};
      bank_rel.valid = 1'b0;
      bank_rel.bank  = cmd_ff.a_bank;
      case (state_ff)
         BK_IDLE: begin
            if (~cmdq_empty) begin
               cmdq_pop = 1'b1;
               cmd_in   = cmdq_head;
               state_in = cmdq_head.a_valid ? BK_A_CODE : BK_M_CODE;
            end
         end
         BK_A_CODE: begin
            if (issue_ok) begin
               iss       = 1'b1;
               iss_const = FULL_CODE;
               idx_in    = 8'd0;
               state_in  = BK_A_DATA;
            end
         end
         BK_A_DATA: begin
            if (issue_ok) begin
               iss     = 1'b1;
               iss_ram = 1'b1;
               idx_in  = idx_ff + 8'd1;
               if (idx_ff == 8'(BLOCK_DEPTH - 1)) begin
                  bank_rel.valid = 1'b1;
                  iss_final      = ~cmd_ff.m_valid;
                  state_in       = cmd_ff.m_valid ? BK_M_CODE : BK_IDLE;
               end
            end
         end
         BK_M_CODE: begin
            if (issue_ok) begin
               iss       = 1'b1;
               iss_const = cmd_ff.m_code;
               idx_in    = 8'd0;
               if (cmd_ff.m_code == EMPTY_CODE) begin
                  iss_final = (after_m == BK_IDLE);
                  state_in  = after_m;
               end else begin
                  state_in = BK_M_DATA;
               end
            end
         end
         BK_M_DATA: begin
            st_rd_addr    = {cmd_ff.m_bank, idx_ff};
            bank_rel.bank = cmd_ff.m_bank;
            if (issue_ok) begin
               iss     = 1'b1;
               iss_ram = 1'b1;
               idx_in  = idx_ff + 8'd1;
               if (idx_ff == cmd_ff.m_code - 8'd2) begin
                  bank_rel.valid = 1'b1;
                  iss_final      = (after_m == BK_IDLE);
                  state_in       = after_m;
               end
            end
         end
         BK_ONE: begin
            if (issue_ok) begin
               iss       = 1'b1;
               iss_const = EMPTY_CODE;
               state_in  = BK_DELIM;
            end
         end
         BK_DELIM: begin
            if (issue_ok) begin
               iss       = 1'b1;
               iss_const = DELIM_BYTE;
               iss_final = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign st_rd_en = iss & iss_ram;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
   end

   // Presented byte: RAM data lines up with this stage, held while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (iss) begin
         pv_ff <= 1'b1;
      end else if (consume) begin
         pv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (iss) begin
         p_ram_ff   <= iss_ram;
         p_const_ff <= iss_const;
         p_final_ff <= iss_final;
         p_eof_ff   <= cmd_ff.eof;
      end
   end

   // Merge the byte into its lane; lanes above it read as zero
   always_comb begin
      for (int k = 0; k < BYTES_PER_WORD; k++) begin
         if (LANE_CNT_W'(k) < cnt_ff) begin
            merged[8*k +: 8] = acc_ff[8*k +: 8];
         end else if (LANE_CNT_W'(k) == cnt_ff) begin
            merged[8*k +: 8] = p_byte;
         end else begin
            merged[8*k +: 8] = 8'h00;
         end
      end
      for (int k = BYTES_PER_WORD; k < 8; k++) begin
         merged[8*k +: 8] = 8'h00;
      end
      word_done = p_final_ff | (cnt_ff == LANE_CNT_W'(BYTES_PER_WORD - 1));
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      if (consume) begin
         acc_in = merged;
         cnt_in = word_done ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (consume & word_done) begin
         ov_ff <= 1'b1;
      end else if (rsp_ready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume & word_done) begin
         ob_ff <= merged;
         oc_ff <= 4'(cnt_ff) + 4'd1;
         ol_ff <= p_final_ff;
         of_ff <= p_final_ff & p_eof_ff;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_bytes   = ob_ff;
   assign rsp_byte_count  = oc_ff;
   assign rsp_last_of_run = ol_ff;
   assign rsp_frame_done  = of_ff;

endmodule

[rtl/cobs_frame_encoder.sv]
// COBS frame encoder. The back end emits one encoded byte per cycle while the
// output is not stalled; a block goes out as its code byte, then its stored bytes,
// and each command is fetched from the queue before its bytes go out.
// Input takes one byte per cycle while the 4-entry command queue has room and the
// store bank to be written is not still being read out. Sync reset: control only.
module cobs_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_last_of_run,
   output logic        rsp_frame_done
);
   import cfe_pkg::*;

   logic                    cmdq_full, cmdq_empty, cmdq_push, cmdq_pop;
   cmd_type                 cmdq_data, cmdq_head;
   logic                    st_wr_en, st_rd_en;
   logic [STORE_ADDR_W-1:0] st_wr_addr, st_rd_addr;
   logic [7:0]              st_wr_data, st_rd_data;
   release_type             bank_rel;

   cfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .cmdq_full        (cmdq_full),
      .cmdq_push        (cmdq_push),
      .cmdq_data        (cmdq_data),
      .st_wr_en         (st_wr_en),
      .st_wr_addr       (st_wr_addr),
      .st_wr_data       (st_wr_data),
      .bank_rel         (bank_rel)
   );

   cfe_cmd_fifo u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_data (cmdq_data),
      .pop       (cmdq_pop),
      .head      (cmdq_head),
      .full      (cmdq_full),
      .empty     (cmdq_empty)
   );

   // Two-bank block store
   cfe_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   cfe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmdq_empty      (cmdq_empty),
      .cmdq_head       (cmdq_head),
      .cmdq_pop        (cmdq_pop),
      .st_rd_en        (st_rd_en),
      .st_rd_addr      (st_rd_addr),
      .st_rd_data      (st_rd_data),
      .bank_rel        (bank_rel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_bytes   (rsp_out_bytes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule

[rtl/cfe_checker.sv]
// Port-level checks for the COBS frame encoder, bound to the top level.
// Depends on cfe_pkg and cobs_frame_encoder.
module cfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_bytes,
   input logic [3:0]  rsp_byte_count,
   input logic        rsp_last_of_run,
   input logic        rsp_frame_done
);
   import cfe_pkg::*;

   // A stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes)
         && $stable(rsp_byte_count) && $stable(rsp_last_of_run))
      else $error("rsp beat changed while stalled");

   // Byte count within one word
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count >= 4'd1 && rsp_byte_count <= 4'(BYTES_PER_WORD))
      else $error("rsp byte count out of range");

   // Only the final word of a run may be short
   a_full_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> rsp_byte_count == 4'(BYTES_PER_WORD))
      else $error("non-final word not full");

   // Delimiter closes the run and sits in the top valid lane
   a_delim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_run
         && ((rsp_out_bytes >> (8 * (rsp_byte_count - 4'd1))) & 64'hFF) == 64'h0)
      else $error("frame delimiter misplaced");

endmodule

bind cobs_frame_encoder cfe_checker u_cfe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_bytes   (rsp_out_bytes),
   .rsp_byte_count  (rsp_byte_count),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_frame_done  (rsp_frame_done)
);

[tb/tb_cobs_frame_encoder.sv]
// Self-checking testbench for cobs_frame_encoder: a directed table followed by
// random and long-run frames, checked beat by beat against a COBS stuffing predictor.
// Depends on rtl/cfe_pkg.sv and rtl/cobs_frame_encoder.sv.
module tb_cobs_frame_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   import cfe_pkg::*;

   localparam int BPW          = BYTES_PER_WORD;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 150;
   localparam int PRINT_CAP    = 50;
   localparam logic [3:0] NO_WORD = 4'd0;

   // One result beat
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic        done;
   } enc_word_type;

   // Directed stimulus row; typed rows carry their expected beat (count 0: none)
   typedef struct packed {
      logic [7:0]  b;
      logic        eof;
      logic        typed;
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic        done;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_frame = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_out_bytes;
   logic [3:0]  rsp_byte_count;
   logic        rsp_last_of_run;
   logic        rsp_frame_done;

   // Predictor state: open block contents and its code
   logic [7:0]   held_bytes [BLOCK_DEPTH];
   logic [7:0]   open_code;
   logic [7:0]   stream_bytes [$];
   enc_word_type run_words [$];
   enc_word_type expected_words [$];

   int          mismatches = 0;
   int          cycle_count = 0;
   logic        hold_rsp_req = 1'b0;
   logic        send_burst = 1'b0;

   stim_row_type directed_rows [24] = '{
      '{8'h00, 1'b1, 1'b1, 64'h0000_0000_0000_0101, 4'd3, 1'b1, 1'b1},
      '{8'hFF, 1'b1, 1'b1, 64'h0000_0000_0000_FF02, 4'd3, 1'b1, 1'b1},
      '{8'h00, 1'b0, 1'b1, 64'h0000_0000_0000_0001, 4'd1, 1'b1, 1'b0},
      '{8'h01, 1'b0, 1'b1, 64'h0,                   NO_WORD, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b1, 64'h0,                   NO_WORD, 1'b0, 1'b0},
      '{8'h7F, 1'b1, 1'b1, 64'h0000_0000_7F80_0104, 4'd5, 1'b1, 1'b1},
      '{8'h55, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'hAA, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h42, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h11, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h22, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h33, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h44, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h55, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h66, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h77, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h88, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h99, 1'b1, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'hFE, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0},
      '{8'h01, 1'b1, 1'b0, 64'h0, NO_WORD, 1'b0, 1'b0}
   };

   cobs_frame_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_bytes    (rsp_out_bytes),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_frame_done   (rsp_frame_done)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Send the open block: code byte, then held bytes; reopen empty
   task automatic flush_open_block();
      int n;
      n = int'(open_code) - 1;
      stream_bytes.push_back(open_code);
      for (int i = 0; i < n; i++)
         stream_bytes.push_back(held_bytes[i]);
      open_code = EMPTY_CODE;
   endtask

   // Stuff one frame byte; leaves the beats it causes in run_words
   task automatic cobs_encode_byte(input logic [7:0] b, input logic eof);
      enc_word_type w;
      int           nwords;
      int           cnt;
      stream_bytes.delete();
      run_words.delete();
      // full block goes out before anything else
      if (open_code == FULL_CODE)
         flush_open_block();
      if (b != 8'h00) begin
         held_bytes[open_code - 8'd1] = b;
         open_code = open_code + 8'd1;
      end else begin
         flush_open_block();
      end
      if (eof) begin
         flush_open_block();
         stream_bytes.push_back(DELIM_BYTE);
      end
      // pack, first byte in lane 0
      nwords = (stream_bytes.size() + BPW - 1) / BPW;
      for (int wi = 0; wi < nwords; wi++) begin
         cnt = stream_bytes.size() - wi * BPW;
         if (cnt > BPW)
            cnt = BPW;
         w.data = '0;
         for (int k = 0; k < cnt; k++)
            w.data[8*k +: 8] = stream_bytes[wi*BPW + k];
         w.count = 4'(cnt);
         w.last  = (wi == nwords - 1);
         w.done  = w.last && eof;
         run_words.push_back(w);
      end
   endtask

   // Offer one byte after a gap; on acceptance queue its expected beats.
   // Entered and left at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic eof, input int gap,
                            input logic typed = 1'b0, input enc_word_type typed_word = '0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_frame <= eof;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      cobs_encode_byte(b, eof);
      if (typed) begin
         if (typed_word.count != NO_WORD)
            expected_words.push_back(typed_word);
      end else begin
         foreach (run_words[i])
            expected_words.push_back(run_words[i]);
      end
      @(negedge clock);
   endtask

   function automatic int draw_gap();
      return send_burst ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [7:0] nonzero_byte();
      return 8'($urandom_range(1, 255));
   endfunction

   // Stop sending until every expected beat has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // n non-zero bytes inside an open frame
   task automatic send_nonzero_run(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
         send_byte(nonzero_byte(), 1'b0, draw_gap());
      end
   endtask

   // Receiver: random stalls per beat, one long hold-off on request
   initial begin : rsp_side
      int           stall;
      logic         burst;
      enc_word_type exp_w;
      burst = 1'b0;
      while (reset)
         @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            burst = !burst;
         stall = burst ? 0 : $urandom_range(0, 8);
         if (hold_rsp_req) begin
            stall = HOLD_CYCLES;
            hold_rsp_req = 1'b0;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         // compare the beat with the oldest expectation
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected beat out_bytes %h count %0d",
                                      rsp_out_bytes, rsp_byte_count));
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_out_bytes !== exp_w.data)
               report_mismatch($sformatf("out_bytes got %h exp %h", rsp_out_bytes,
                                         exp_w.data));
            if (rsp_byte_count !== exp_w.count)
               report_mismatch($sformatf("byte_count got %0d exp %0d", rsp_byte_count,
                                         exp_w.count));
            if (rsp_last_of_run !== exp_w.last)
               report_mismatch($sformatf("last_of_run got %b exp %b", rsp_last_of_run,
                                         exp_w.last));
            if (rsp_frame_done !== exp_w.done)
               report_mismatch($sformatf("frame_done got %b exp %b", rsp_frame_done,
                                         exp_w.done));
         end
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin : req_side
      int           rand_items;
      int           kind;
      int           len;
      enc_word_type tw;
      logic [7:0]   b;
      logic         eof;

      open_code = EMPTY_CODE;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         tw.data  = directed_rows[i].data;
         tw.count = directed_rows[i].count;
         tw.last  = directed_rows[i].last;
         tw.done  = directed_rows[i].done;
         send_byte(directed_rows[i].b, directed_rows[i].eof, draw_gap(),
                   directed_rows[i].typed, tw);
      end
      drain_results();

      // receiver holds off while back-to-back zeros fill the command queue
      hold_rsp_req = 1'b1;
      for (int i = 0; i < 12; i++)
         send_byte(8'h00, (i == 11), 0);
      drain_results();

      // full block at frame end: no trailing empty block
      send_nonzero_run(253);
      send_byte(8'h5A, 1'b1, draw_gap());
      // full block pending, then a non-zero byte ends the frame
      send_nonzero_run(254);
      send_byte(8'h33, 1'b1, draw_gap());
      // full block pending, then a zero byte, frame goes on
      send_nonzero_run(254);
      send_byte(8'h00, 1'b0, draw_gap());
      send_byte(8'hC3, 1'b1, draw_gap());
      // full block pending, then a zero byte that ends the frame
      send_nonzero_run(254);
      send_byte(8'h00, 1'b1, draw_gap());
      // two full blocks in one frame
      send_nonzero_run(508);
      send_byte(8'h00, 1'b1, draw_gap());
      drain_results();

      // random frames
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         send_burst = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 15);
         if (kind == 0) begin
            // long run around the block limit
            len = $urandom_range(250, 258);
            send_nonzero_run(len);
            send_byte(8'($urandom_range(0, 255)), 1'b1, draw_gap());
            rand_items += len + 1;
         end else if (kind <= 3) begin
            // raw bytes with stray frame ends
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               b   = 8'($urandom_range(0, 255));
               eof = ($urandom_range(0, 3) == 0);
               send_byte(b, eof, draw_gap());
            end
            rand_items += len;
         end else begin
            // short frame, zero-rich content
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) begin
               b = ($urandom_range(0, 3) == 0) ? 8'h00 : nonzero_byte();
               send_byte(b, (i == len - 1), draw_gap());
            end
            rand_items += len;
         end
      end

      // let the last beats drain, then a short quiet window
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[files.f]
rtl/cfe_pkg.sv
rtl/cfe_ram.sv
rtl/cfe_front.sv
rtl/cfe_cmd_fifo.sv
rtl/cfe_back.sv
rtl/cobs_frame_encoder.sv
rtl/cfe_checker.sv
tb/tb_cobs_frame_encoder.sv
